// ----- rtl/cvss_pkg.sv -----
package cvss_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_FETCH_AT,
        ST_PICK,
        ST_RESULT
    } state_t;

    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned VALUE_W = 32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic load_query;
        logic mem_write;
        logic probe;
        logic step;
        logic fetch_below;
        logic fetch_at;
        logic pick;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic size_zero;
        logic search_open;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/cvss_ctrl.sv -----
module cvss_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    input  cvss_pkg::stat_t stat,
    output cvss_pkg::cmd_t  cmd
);

    cvss_pkg::state_t state_reg;
    cvss_pkg::state_t state_next;
    logic             accept;

    assign in_ready = (state_reg == cvss_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvss_pkg::ST_IDLE:
            begin
                if (accept && (kind == cvss_pkg::KIND_QUERY))
                begin
                    if (stat.size_zero)
                    begin
                        state_next = cvss_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = cvss_pkg::ST_PROBE;
                    end
                end
            end
            cvss_pkg::ST_PROBE:
            begin
                if (stat.search_open)
                begin
                    state_next = cvss_pkg::ST_COMPARE;
                end
                else
                begin
                    state_next = cvss_pkg::ST_FETCH_AT;
                end
            end
            cvss_pkg::ST_COMPARE:  state_next = cvss_pkg::ST_PROBE;
            cvss_pkg::ST_FETCH_AT: state_next = cvss_pkg::ST_PICK;
            cvss_pkg::ST_PICK:     state_next = cvss_pkg::ST_RESULT;
            cvss_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = cvss_pkg::ST_IDLE;
                end
            end
            default:               state_next = cvss_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            cvss_pkg::ST_IDLE:
            begin
                cmd.load_query = accept && (kind == cvss_pkg::KIND_QUERY);
                cmd.mem_write  = accept && (kind == cvss_pkg::KIND_WRITE);
            end
            cvss_pkg::ST_PROBE:
            begin
                cmd.probe       = stat.search_open;
                cmd.fetch_below = !stat.search_open;
            end
            cvss_pkg::ST_COMPARE:  cmd.step     = 1'b1;
            cvss_pkg::ST_FETCH_AT: cmd.fetch_at = 1'b1;
            cvss_pkg::ST_PICK:     cmd.pick     = 1'b1;
            cvss_pkg::ST_RESULT:   cmd.emit     = stat.out_free;
            default:               cmd          = '0;
        endcase
    end

endmodule

// ----- rtl/cvss_datapath.sv -----
module cvss_datapath
#(
    parameter int unsigned TABLE_DEPTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cvss_pkg::SIZE_W-1:0]         cfg_data,
    input  logic [cvss_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [cvss_pkg::VALUE_W-1:0] entry_value,
    input  logic signed [cvss_pkg::VALUE_W-1:0] query_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cvss_pkg::VALUE_W-1:0] closest,
    output logic                                status,
    input  cvss_pkg::cmd_t                      cmd,
    output cvss_pkg::stat_t                     stat
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned VW     = cvss_pkg::VALUE_W;

    logic [VW-1:0]                  mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]              rd_addr;
    logic                           rd_en;
    logic signed [VW-1:0]           rd_data_reg;
    logic                           wr_ok;

    logic [cvss_pkg::SIZE_W-1:0]    table_size_reg;
    logic [cvss_pkg::SIZE_W-1:0]    table_size_next;
    logic [CNT_W-1:0]               size_eff;

    logic [CNT_W-1:0]               size_reg;
    logic [CNT_W-1:0]               size_next;
    logic [CNT_W-1:0]               low_reg;
    logic [CNT_W-1:0]               low_next;
    logic [CNT_W-1:0]               high_reg;
    logic [CNT_W-1:0]               high_next;
    logic [CNT_W-1:0]               mid_reg;
    logic [CNT_W-1:0]               mid_next;
    logic [CNT_W-1:0]               mid;
    logic [CNT_W-1:0]               addr_below;
    logic [CNT_W-1:0]               addr_at;
    logic                           past_end;

    logic signed [VW-1:0]           q_reg;
    logic signed [VW-1:0]           q_next;
    logic signed [VW-1:0]           below_reg;
    logic signed [VW-1:0]           below_next;
    logic signed [VW-1:0]           result_reg;
    logic signed [VW-1:0]           result_next;
    logic                           invalid_reg;
    logic                           invalid_next;

    logic signed [VW:0]             diff_below;
    logic signed [VW:0]             diff_at;
    logic [VW:0]                    dist_below;
    logic [VW:0]                    dist_at;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [VW-1:0]           closest_reg;
    logic signed [VW-1:0]           closest_next;
    logic                           status_reg;
    logic                           status_next;

    assign cfg_ready = 1'b1;

    // table_size above the depth saturates to the depth
    always_comb
    begin
        if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            size_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            size_eff = CNT_W'(table_size_reg);
        end
    end

    assign mid      = low_reg + ((high_reg - low_reg) >> 1);
    assign past_end = (low_reg >= size_reg);

    // Neighbors: at the ends both reads hit the same entry, so the tie rule
    // picks it without a special path.
    always_comb
    begin
        if (past_end)
        begin
            addr_below = size_reg - CNT_W'(1);
            addr_at    = size_reg - CNT_W'(1);
        end
        else if (low_reg == '0)
        begin
            addr_below = '0;
            addr_at    = '0;
        end
        else
        begin
            addr_below = low_reg - CNT_W'(1);
            addr_at    = low_reg;
        end
    end

    assign rd_en = cmd.probe || cmd.fetch_below || cmd.fetch_at;

    always_comb
    begin
        if (cmd.probe)
        begin
            rd_addr = mid[ADDR_W-1:0];
        end
        else if (cmd.fetch_below)
        begin
            rd_addr = addr_below[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = addr_at[ADDR_W-1:0];
        end
    end

    assign wr_ok = cmd.mem_write && (32'(entry_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[ADDR_W'(entry_index)] <= entry_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // exact 33-bit distances
    assign diff_below = $signed({q_reg[VW-1], q_reg}) - $signed({below_reg[VW-1], below_reg});
    assign diff_at    = $signed({q_reg[VW-1], q_reg}) - $signed({rd_data_reg[VW-1], rd_data_reg});
    assign dist_below = diff_below[VW] ? (VW+1)'(-diff_below) : (VW+1)'(diff_below);
    assign dist_at    = diff_at[VW] ? (VW+1)'(-diff_at) : (VW+1)'(diff_at);

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_valid && cfg_ready)
        begin
            table_size_next = cfg_data;
        end

        size_next    = size_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        q_next       = q_reg;
        below_next   = below_reg;
        result_next  = result_reg;
        invalid_next = invalid_reg;

        if (cmd.load_query)
        begin
            size_next    = size_eff;
            low_next     = '0;
            high_next    = size_eff;
            q_next       = query_value;
            result_next  = '0;
            invalid_next = (size_eff == '0) ? cvss_pkg::STATUS_INVALID : cvss_pkg::STATUS_OK;
        end
        if (cmd.probe)
        begin
            mid_next = mid;
        end
        if (cmd.step)
        begin
            if (q_reg <= rd_data_reg)
            begin
                high_next = mid_reg;
            end
            else
            begin
                low_next = mid_reg + CNT_W'(1);
            end
        end
        if (cmd.fetch_at)
        begin
            below_next = rd_data_reg;
        end
        if (cmd.pick)
        begin
            result_next = (dist_below <= dist_at) ? below_reg : rd_data_reg;
        end

        out_valid_next = out_valid_reg;
        closest_next   = closest_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            closest_next   = result_reg;
            status_next    = invalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            table_size_reg <= table_size_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        mid_reg     <= mid_next;
        q_reg       <= q_next;
        below_reg   <= below_next;
        result_reg  <= result_next;
        invalid_reg <= invalid_next;
        closest_reg <= closest_next;
        status_reg  <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign closest   = closest_reg;
    assign status    = status_reg;

    assign stat.size_zero   = (size_eff == '0);
    assign stat.search_open = (low_reg < high_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;

endmodule

// ----- rtl/closest_value_sorted_search.sv -----
// Nearest-value search over a sorted table held in a single-port memory of
// TABLE_DEPTH signed 32-bit words. A write transaction (kind 0) stores one
// entry and gives no result; a query (kind 1) runs a lower-bound binary
// search over the first table_size entries (saturated to TABLE_DEPTH) and
// returns the nearest stored value, ties to the lower neighbor; size zero
// gives status 1 and closest 0. Each search step is a memory read, then a
// compare, as the one memory read port sets; after the search the two
// neighbors are read, the nearer one is picked and the result is emitted.
// Items are handled one at a time; a new item is taken while a finished
// result still waits on the output. The table is not cleared by reset, and
// table_size must be written by the user only while the block is idle; the
// block itself does not enforce this.
module closest_value_sorted_search
#(
    parameter int unsigned TABLE_DEPTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cvss_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [cvss_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [cvss_pkg::VALUE_W-1:0] entry_value,
    input  logic signed [cvss_pkg::VALUE_W-1:0] query_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cvss_pkg::VALUE_W-1:0] closest,
    output logic                                status
);

    cvss_pkg::cmd_t  cmd;
    cvss_pkg::stat_t stat;

    cvss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    cvss_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .query_value (query_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .closest     (closest),
        .status      (status),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- dv/closest_value_sorted_search_tb.sv -----
`timescale 1ns / 1ps

typedef struct {
    logic signed [cvss_pkg::VALUE_W-1:0] closest;
    logic                                status;
} search_answer_t;

class nearest_scoreboard #(int unsigned DEPTH = 1024);

    logic signed [cvss_pkg::VALUE_W-1:0] entries [DEPTH];
    int unsigned                         search_size;
    search_answer_t                      expected_answers [$];
    int                                  mismatches;
    int                                  writes;
    int                                  queries;
    int                                  invalids;

    function new();
        foreach (entries[i])
            entries[i] = '0;
        search_size = 0;
        mismatches  = 0;
        writes      = 0;
        queries     = 0;
        invalids    = 0;
    endfunction

    function void set_size(logic [cvss_pkg::SIZE_W-1:0] v);
        search_size = (v > DEPTH) ? DEPTH : v;
    endfunction

    function int pending();
        return expected_answers.size();
    endfunction

    function longint span(longint a, longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Predicts the answer to one accepted transaction; writes update the table only.
    function void note_item(logic k, logic [cvss_pkg::INDEX_W-1:0] idx,
                            logic signed [cvss_pkg::VALUE_W-1:0] ev,
                            logic signed [cvss_pkg::VALUE_W-1:0] qv);
        search_answer_t a;
        longint         q;
        longint         below;
        longint         at;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        if (k == cvss_pkg::KIND_WRITE)
        begin
            if (idx < DEPTH)
                entries[idx] = ev;
            writes++;
            return;
        end
        queries++;
        if (search_size == 0)
        begin
            a.closest = '0;
            a.status  = cvss_pkg::STATUS_INVALID;
            invalids++;
            expected_answers.push_back(a);
            return;
        end
        q  = qv;
        lo = 0;
        hi = search_size;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (q <= longint'(entries[mid]))
                hi = mid;
            else
                lo = mid + 1;
        end
        if (lo >= search_size)
            a.closest = entries[search_size-1];
        else if (lo == 0)
            a.closest = entries[0];
        else
        begin
            below = entries[lo-1];
            at    = entries[lo];
            // tie goes to the lower neighbor
            a.closest = (span(q, below) <= span(q, at)) ? entries[lo-1] : entries[lo];
        end
        a.status = cvss_pkg::STATUS_OK;
        expected_answers.push_back(a);
    endfunction

    function void check_answer(logic signed [cvss_pkg::VALUE_W-1:0] closest, logic status);
        search_answer_t e;
        if (expected_answers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t: result with no query waiting: closest %0d status %0d",
                         $realtime, closest, status);
            return;
        end
        e = expected_answers.pop_front();
        if (closest !== e.closest || status !== e.status)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t: closest/status expected %0d/%0d, got %0d/%0d",
                         $realtime, e.closest, e.status, closest, status);
        end
    endfunction

endclass

module closest_value_sorted_search_tb;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam longint      VAL_MIN     = -64'sd2147483648;
    localparam longint      VAL_MAX     = 64'sd2147483647;
    localparam int          SETTLE      = 64;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [cvss_pkg::SIZE_W-1:0]         cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic                                kind;
    logic [cvss_pkg::INDEX_W-1:0]        entry_index;
    logic signed [cvss_pkg::VALUE_W-1:0] entry_value;
    logic signed [cvss_pkg::VALUE_W-1:0] query_value;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [cvss_pkg::VALUE_W-1:0] closest;
    logic                                status;

    nearest_scoreboard #(TABLE_DEPTH) sb;

    bit          tx_idle_en;
    bit          rx_idle_en;
    int          rx_hold;
    int unsigned cur_n;
    int          settings;

    closest_value_sorted_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .query_value (query_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .closest     (closest),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic longint pick_between(longint lo, longint hi);
        bit [63:0] width;
        bit [63:0] r;
        width = hi - lo + 1;
        r     = {$urandom, $urandom};
        return lo + longint'(r % width);
    endfunction

    function automatic longint pick_query();
        int unsigned i;
        if (cur_n == 0)
            return longint'($urandom);
        i = $urandom_range(0, cur_n - 1);
        case ($urandom_range(0, 7))
            0: return sb.entries[i];
            1: return longint'(sb.entries[i]) + 1;
            2: return longint'(sb.entries[i]) - 1;
            3:
            begin
                // midpoint of a neighbor pair, a tie when the sum is even
                if (i + 1 < cur_n)
                    return (longint'(sb.entries[i]) + longint'(sb.entries[i+1])) / 2;
                return sb.entries[i];
            end
            4: return VAL_MIN;
            5: return VAL_MAX;
            default: return longint'($urandom);
        endcase
    endfunction

    task automatic send_item(logic k, int unsigned idx, longint ev, longint qv);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        entry_index <= idx[cvss_pkg::INDEX_W-1:0];
        entry_value <= ev[cvss_pkg::VALUE_W-1:0];
        query_value <= qv[cvss_pkg::VALUE_W-1:0];
        do @(posedge clk); while (!in_ready);
        sb.note_item(k, idx[cvss_pkg::INDEX_W-1:0], ev[cvss_pkg::VALUE_W-1:0],
                     qv[cvss_pkg::VALUE_W-1:0]);
    endtask

    task automatic send_query(longint qv);
        send_item(cvss_pkg::KIND_QUERY, $urandom_range(0, TABLE_DEPTH - 1),
                  longint'($urandom), qv);
    endtask

    // Writes may still be in flight after the last answer, so allow a settle gap.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[cvss_pkg::SIZE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_size(v[cvss_pkg::SIZE_W-1:0]);
        cur_n = (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
        settings++;
    endtask

    task automatic fill_sorted(int unsigned n, int unsigned step_max);
        longint      v;
        longint      limit;
        int unsigned i;
        limit = VAL_MAX - longint'(n) * longint'(step_max);
        if (limit < VAL_MIN)
            v = VAL_MIN + $urandom_range(0, step_max);
        else
            v = pick_between(VAL_MIN, limit);
        for (i = 0; i < n; i++)
        begin
            send_item(cvss_pkg::KIND_WRITE, i, v, longint'($urandom));
            v += $urandom_range(0, step_max);
            if (v > VAL_MAX)
                v = VAL_MAX;
        end
    endtask

    task automatic random_write();
        int unsigned idx;
        longint      lo;
        longint      hi;
        longint      tmp;
        if (cur_n > 1 && $urandom_range(0, 4) != 0)
            idx = $urandom_range(0, cur_n - 1);
        else
            idx = $urandom_range(0, TABLE_DEPTH - 1);
        if ($urandom_range(0, 4) == 0)
        begin
            send_item(cvss_pkg::KIND_WRITE, idx, longint'($urandom), longint'($urandom));
            return;
        end
        // keep the table ordered around the written slot
        lo = (idx > 0) ? longint'(sb.entries[idx-1]) : VAL_MIN;
        hi = (idx < TABLE_DEPTH - 1) ? longint'(sb.entries[idx+1]) : VAL_MAX;
        if (lo > hi)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        send_item(cvss_pkg::KIND_WRITE, idx, pick_between(lo, hi), longint'($urandom));
    endtask

    initial
    begin : receiver
        int rx_wait;
        rx_wait = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_answer(closest, status);
                rx_wait = rx_idle_en ? $urandom_range(0, 11) : 0;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        longint      seed_vals [8];
        longint      probes [8];
        int unsigned steps [4];
        int unsigned v;
        int          ph;
        int          j;
        seed_vals = '{VAL_MIN, -100, -10, 0, 10, 20, 1000, VAL_MAX};
        probes    = '{VAL_MIN, VAL_MAX, 15, -55, 16, 5, 1073741823, -2147483647};
        steps     = '{1, 3, 1000, 1 << 26};
        sb          = new();
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold     = 0;
        cur_n       = 0;
        settings    = 0;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        kind        <= cvss_pkg::KIND_WRITE;
        entry_index <= '0;
        entry_value <= '0;
        query_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size is zero out of reset: invalid answers
        send_query(VAL_MIN);
        send_query(VAL_MAX);
        foreach (seed_vals[i])
            send_item(cvss_pkg::KIND_WRITE, i, seed_vals[i], longint'($urandom));
        write_size(8);
        foreach (probes[i])
            send_query(probes[i]);
        // lower bound past the end of the searched range
        write_size(6);
        send_query(VAL_MAX);
        send_query(25);
        send_query(19);
        write_size(1);
        send_query(VAL_MAX);
        send_query(VAL_MIN);

        // whole table written once, so any size is safe from here on
        fill_sorted(TABLE_DEPTH, 1 << 23);

        for (ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0:  v = 1024;
                1:  v = 2047;
                2:  v = 3;
                3:  v = 0;
                4:  v = 1;
                5:  v = 2;
                6:  v = 1025;
                7:  v = $urandom_range(1, 16);
                8:  v = $urandom_range(1, 64);
                9:  v = $urandom_range(1, 2047);
                10: v = $urandom_range(1, 1024);
                12: v = 5;
                13: v = $urandom_range(1, 64);
                default: v = 1024;
            endcase
            write_size(v);
            tx_idle_en = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle_en = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (cur_n > 0 && cur_n <= 64)
                fill_sorted(cur_n, steps[$urandom_range(0, 3)]);
            for (j = 0; j < 27; j++)
            begin
                // long output stall with input still offered: block must back up
                if (ph == 2 && j == 10)
                    rx_hold = 400;
                if ($urandom_range(0, 3) == 0)
                    random_write();
                else
                    send_query(pick_query());
            end
        end

        drain();
        $display("Ran %0d table writes and %0d nearest-value queries (%0d with empty table)",
                 sb.writes, sb.queries, sb.invalids);
        $display("over %0d table-size settings, including 0, 1, 1024 and saturated sizes",
                 settings);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
